[hdl/cube_surface_color_wipe_top_assert.svh]
// Assertion macros used by the checker of this block.
`ifndef CUBE_SURFACE_COLOR_WIPE_TOP_ASSERT_SVH
`define CUBE_SURFACE_COLOR_WIPE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define CSW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define CSW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/csw_pkg.sv]
package csw_pkg;

  // Fixed point scale and path geometry
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned POS_W        = 22;
  localparam int unsigned MAG_W        = 21;
  localparam int unsigned QUOT_W       = 16;
  localparam logic [POS_W-1:0] PATH_LEN = POS_W'(48 * 65536);
  localparam int unsigned HALF_PATH    = 24 * 65536;
  localparam logic [15:0] TENTH        = 16'd6554;
  localparam logic [14:0] THREE_TENTHS = 15'd19661;
  localparam logic [8:0] HUE_STEP      = 9'd30;
  localparam logic [8:0] HUE_FULL      = 9'd360;

  // Register reset values
  localparam logic [15:0] WAVE_SPEED_RST  = 16'd655;
  localparam logic [12:0] LEAD_WIDTH_RST  = 13'd1024;
  localparam logic [12:0] TAIL_LENGTH_RST = 13'd2048;

  // Configuration register indexes
  localparam logic [1:0] CFG_WAVE_SPEED  = 2'd0;
  localparam logic [1:0] CFG_LEAD_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_TAIL_LENGTH = 2'd2;

  // Item kinds
  localparam logic ACT_ADVANCE = 1'b0;
  localparam logic ACT_SHADE   = 1'b1;

  // Face codes
  localparam logic [2:0] FACE_FRONT  = 3'd0;
  localparam logic [2:0] FACE_BACK   = 3'd1;
  localparam logic [2:0] FACE_LEFT   = 3'd2;
  localparam logic [2:0] FACE_RIGHT  = 3'd3;
  localparam logic [2:0] FACE_TOP    = 3'd4;
  localparam logic [2:0] FACE_BOTTOM = 3'd5;

  typedef struct packed {
    logic        action;
    logic [15:0] elapsed_ms;
    logic [2:0]  face;
    logic [2:0]  column;
    logic [2:0]  row;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic adv_mul;
    logic adv_upd;
    logic pos;
    logic delta;
    logic div_go1;
    logic bri;
    logic ck;
    logic scale;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

  // n * 0.1 pixel, Q.16
  function automatic logic [15:0] tenth_of(input logic [2:0] n);
    tenth_of = 16'({13'd0, n} * TENTH);
  endfunction

endpackage

[hdl/csw_div.sv]
module csw_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [csw_pkg::MAG_W-1:0]  rem_init_i,
  input  logic [csw_pkg::QUOT_W-1:0] num_i,
  input  logic [csw_pkg::MAG_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [csw_pkg::QUOT_W-1:0] quot_o
);
  import csw_pkg::*;

  logic              busy_q;
  logic [3:0]        cnt_q;
  logic [MAG_W-1:0]  rem_q, rem_d;
  logic [MAG_W-1:0]  div_q;
  logic [QUOT_W-1:0] num_q;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [MAG_W:0]    trial;
  logic              fits;

  // One restoring step: shift in the next numerator bit, try to subtract
  always_comb begin
    trial  = {rem_q, num_q[QUOT_W-1]};
    fits   = trial >= {1'b0, div_q};
    rem_d  = fits ? MAG_W'(trial - {1'b0, div_q}) : trial[MAG_W-1:0];
    quot_d = {quot_q[QUOT_W-2:0], fits};
  end

  assign done_o = busy_q && (cnt_q == 4'(QUOT_W - 1));
  assign quot_o = quot_q;

  // Control: busy flag and step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 4'd1;
      if (done_o) busy_q <= 1'b0;
    end
  end

  // Operands and partial results
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= rem_init_i;
      div_q  <= divisor_i;
      num_q  <= num_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      num_q  <= {num_q[QUOT_W-2:0], 1'b0};
      quot_q <= quot_d;
    end
  end

endmodule

[hdl/csw_dp.sv]
module csw_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [15:0]    cfg_data_i,
  input  csw_pkg::in_t   in_data_i,
  input  csw_pkg::cmd_t  cmd_i,
  output csw_pkg::sts_t  sts_o,
  output csw_pkg::out_t  out_data_o,
  output logic           out_valid_o,
  input  logic           out_stall_i
);
  import csw_pkg::*;

  logic [15:0]      wave_speed_q;
  logic [12:0]      lead_width_q, tail_length_q;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [8:0]       hue_q, hue_d;
  in_t              item_q;
  logic [31:0]      prod_q;
  logic [POS_W-1:0] p_q, p_d;
  logic [MAG_W-1:0] mag_q, mag_d;
  logic             neg_q, lead_q, tail_q, lead_d, tail_d;
  logic [6:0]       off_q, off_d;
  logic [16:0]      b_q, b_d;
  logic [8:0]       h_q, h_d;
  logic [2:0]       sec_q, sec_d;
  logic [7:0]       c_q;
  logic [22:0]      bk_q;
  logic [7:0]       n_q;
  out_t             out_q, out_d;
  logic             out_valid_q;

  logic [MAG_W-1:0] lw, tl;
  logic             div_start, div_done;
  logic [MAG_W-1:0] div_rem, div_divisor;
  logic [QUOT_W-1:0] div_num, quot;

  assign lw = {lead_width_q, 8'd0};
  assign tl = {tail_length_q, 8'd0};

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_speed_q  <= WAVE_SPEED_RST;
      lead_width_q  <= LEAD_WIDTH_RST;
      tail_length_q <= TAIL_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WAVE_SPEED:  wave_speed_q  <= cfg_data_i;
        CFG_LEAD_WIDTH:  lead_width_q  <= cfg_data_i[12:0];
        CFG_TAIL_LENGTH: tail_length_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // Wave advance: saturate the step, wrap the position, step the hue on a wrap
  always_comb begin
    logic [POS_W-1:0] step;
    logic [POS_W:0]   sum;
    logic [8:0]       h30;
    step = (prod_q > 32'(PATH_LEN - 1'b1)) ? PATH_LEN - 1'b1 : prod_q[POS_W-1:0];
    sum  = {1'b0, pos_q} + {1'b0, step};
    h30  = hue_q + HUE_STEP;
    pos_d = sum[POS_W-1:0];
    hue_d = hue_q;
    if (sum >= {1'b0, PATH_LEN}) begin
      pos_d = POS_W'(sum - {1'b0, PATH_LEN});
      hue_d = (h30 >= HUE_FULL) ? h30 - HUE_FULL : h30;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      hue_q <= '0;
    end else if (cmd_i.adv_upd) begin
      pos_q <= pos_d;
      hue_q <= hue_d;
    end
  end

  // Surface position of the pixel
  always_comb begin
    logic [5:0] seg;
    logic [2:0] coord;
    logic [2:0] slant;
    logic       known;
    known = 1'b1;
    seg   = '0;
    coord = item_q.column;
    slant = 3'd7 - item_q.row;
    case (item_q.face)
      FACE_FRONT:  seg = 6'd0;
      FACE_RIGHT:  seg = 6'd8;
      FACE_BACK:   seg = 6'd16;
      FACE_LEFT:   seg = 6'd24;
      FACE_TOP: begin
        seg   = 6'd32;
        coord = item_q.row;
        slant = item_q.column;
      end
      FACE_BOTTOM: begin
        seg   = 6'd40;
        coord = 3'd7 - item_q.row;
        slant = item_q.column;
      end
      default: known = 1'b0;
    endcase
    p_d = known ? {seg + {3'd0, coord}, 16'd0} + {6'd0, tenth_of(slant)} : '0;
  end

  // Wrapped distance, zone test and hue offset
  always_comb begin
    logic signed [23:0] d, dw;
    logic [22:0]        m5;
    d  = $signed({2'b0, pos_q}) - $signed({2'b0, p_q});
    dw = d;
    if (d < -24'sd1572864)     dw = d + $signed({2'b0, PATH_LEN});
    else if (d > 24'sd1572864) dw = d - $signed({2'b0, PATH_LEN});
    mag_d  = dw[23] ? MAG_W'(-dw) : dw[MAG_W-1:0];
    lead_d = !dw[23] && (mag_d < lw);
    tail_d = dw[23] && (mag_d < tl);
    m5     = {2'b0, mag_d} + {mag_d, 2'b0};
    off_d  = m5[22:16];
  end

  // Brightness from the quotient, hue with wrap
  always_comb begin
    logic [16:0]        f;
    logic [31:0]        fm;
    logic signed [10:0] hs;
    f  = 17'h10000 - {1'b0, quot};
    fm = 32'(f * THREE_TENTHS);
    if (lead_q)      b_d = f;
    else if (tail_q) b_d = {1'b0, fm[31:16]};
    else             b_d = '0;
    hs = neg_q ? $signed({2'b0, hue_q}) - $signed({4'b0, off_q})
               : $signed({2'b0, hue_q}) + $signed({4'b0, off_q});
    if (hs < 11'sd0)        hs = hs + 11'sd360;
    else if (hs >= 11'sd360) hs = hs - 11'sd360;
    h_d = hs[8:0];
  end

  // Sector and ramp of the hue
  logic [5:0] k;
  always_comb begin
    logic [8:0] t;
    if (h_q < 9'd60)       sec_d = 3'd0;
    else if (h_q < 9'd120) sec_d = 3'd1;
    else if (h_q < 9'd180) sec_d = 3'd2;
    else if (h_q < 9'd240) sec_d = 3'd3;
    else if (h_q < 9'd300) sec_d = 3'd4;
    else                   sec_d = 3'd5;
    if (h_q < 9'd120)      t = h_q;
    else if (h_q < 9'd240) t = h_q - 9'd120;
    else                   t = h_q - 9'd240;
    k = (t > 9'd60) ? 6'(9'd120 - t) : t[5:0];
  end

  // Final RGB placement
  always_comb begin
    logic [7:0] xv;
    xv    = n_q;
    out_d = '0;
    case (sec_q)
      3'd0: begin out_d.red = c_q;  out_d.green = xv;  end
      3'd1: begin out_d.red = xv;   out_d.green = c_q; end
      3'd2: begin out_d.green = c_q; out_d.blue = xv;  end
      3'd3: begin out_d.green = xv;  out_d.blue = c_q; end
      3'd4: begin out_d.red = xv;   out_d.blue = c_q;  end
      default: begin out_d.red = c_q; out_d.blue = xv; end
    endcase
  end

  // Pipeline of working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) item_q <= in_data_i;
    if (cmd_i.adv_mul) prod_q <= 32'(item_q.elapsed_ms * wave_speed_q);
    if (cmd_i.pos)     p_q <= p_d;
    if (cmd_i.delta) begin
      mag_q  <= mag_d;
      // hue offset is subtracted only in the trail
      neg_q  <= tail_d;
      lead_q <= lead_d;
      tail_q <= tail_d;
      off_q  <= off_d;
    end
    if (cmd_i.bri) begin
      b_q <= b_d;
      h_q <= h_d;
    end
    if (cmd_i.ck) begin
      sec_q <= sec_d;
      c_q   <= 8'(({b_q, 8'd0} - {8'd0, b_q}) >> 16);
      bk_q  <= 23'(b_q * k);
    end
    // b*k*255/(60*65536) equals b*k*17/2^18 exactly
    if (cmd_i.scale) n_q <= 8'(({bk_q, 4'd0} + {4'd0, bk_q}) >> 18);
    if (cmd_i.out_load) out_q <= out_d;
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Serial divider for the brightness fraction
  assign div_start   = cmd_i.div_go1;
  assign div_rem     = mag_q;
  assign div_num     = '0;
  assign div_divisor = tail_q ? tl : lw;

  csw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_init_i (div_rem),
    .num_i      (div_num),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_data_o     = out_q;
  assign out_valid_o    = out_valid_q;

endmodule

[hdl/csw_ctrl.sv]
module csw_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_action_i,
  output logic          in_stall_o,
  input  csw_pkg::sts_t sts_i,
  output csw_pkg::cmd_t cmd_o
);
  import csw_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b00000000001,
    ST_ADV_MUL = 11'b00000000010,
    ST_ADV_UPD = 11'b00000000100,
    ST_POS     = 11'b00000001000,
    ST_DIST    = 11'b00000010000,
    ST_LD1     = 11'b00000100000,
    ST_DIV1    = 11'b00001000000,
    ST_BRI     = 11'b00010000000,
    ST_CK      = 11'b00100000000,
    ST_SCALE   = 11'b01000000000,
    ST_OUT     = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = (in_action_i == ACT_ADVANCE) ? ST_ADV_MUL : ST_POS;
        end
      end
      ST_ADV_MUL: begin
        cmd_o.adv_mul = 1'b1;
        state_d = ST_ADV_UPD;
      end
      ST_ADV_UPD: begin
        cmd_o.adv_upd = 1'b1;
        state_d = ST_IDLE;
      end
      ST_POS: begin
        cmd_o.pos = 1'b1;
        state_d = ST_DIST;
      end
      ST_DIST: begin
        cmd_o.delta = 1'b1;
        state_d = ST_LD1;
      end
      ST_LD1: begin
        cmd_o.div_go1 = 1'b1;
        state_d = ST_DIV1;
      end
      ST_DIV1: if (sts_i.div_done) state_d = ST_BRI;
      ST_BRI: begin
        cmd_o.bri = 1'b1;
        state_d = ST_CK;
      end
      ST_CK: begin
        cmd_o.ck = 1'b1;
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

[hdl/cube_surface_color_wipe_top.sv]
// Color wave around the surface of a six-face 8x8 LED cube.
// Input channel (in_valid_i / in_stall_o / in_data_i): an advance transaction
// moves the wave by wave_speed * elapsed_ms and produces no result; a shade
// transaction maps face, column and row to a surface position and produces
// one RGB result on the output channel (out_valid_o / out_stall_i / out_data_o).
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 wave_speed, 1 lead_width, 2 tail_length); write only while idle.
// A shade transaction runs the 16-step serial divider for the brightness
// fraction; the ramp scale is a constant multiply. The block takes no new
// transaction until the current one is done.
// The output register holds a result until taken; the block accepts the next
// transaction meanwhile, and a finished shade waits only if the earlier
// result is still stalled.
// Reset clears wave position and hue to zero and loads the register defaults.
module cube_surface_color_wipe_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  csw_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output csw_pkg::out_t out_data_o
);
  import csw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  csw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_data_i.action),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  csw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

endmodule

[hdl/csw_chk.sv]
`include "cube_surface_color_wipe_top_assert.svh"

module csw_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input csw_pkg::out_t out_data_o
);

  // A stalled result stays put
  `CSW_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")

  // An accepted transaction makes the block busy
  `CSW_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "not busy after accept")

  // A new result is posted as the block returns to idle
  `CSW_ASSERT_IMP(a_idle_on_result, $rose(out_valid_o), !in_stall_o, "result without return to idle")

endmodule

bind cube_surface_color_wipe_top csw_chk u_chk (.*);
